// ===== rtl/core/dect_pkg.sv =====
// Shared types and codes for the delayed event countdown table.
`default_nettype none

package dect_pkg;

  localparam int FIELD_W = 16;
  localparam int KIND_W  = 2;

  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [KIND_W-1:0]  kind_t;

  localparam kind_t KIND_REQ   = 2'd0;
  localparam kind_t KIND_TICK  = 2'd1;
  localparam kind_t KIND_CLEAR = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/dect_in_if.sv =====
// Input channel: request, tick and clear items.
`default_nettype none

interface dect_in_if;
  logic            valid;
  logic            ready;
  dect_pkg::kind_t kind;
  dect_pkg::field_t sound_id;
  dect_pkg::field_t delay;
  dect_pkg::field_t gain;
  logic            halt_audio;

  modport source (output valid, kind, sound_id, delay, gain, halt_audio, input ready);
  modport sink   (input valid, kind, sound_id, delay, gain, halt_audio, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dect_out_if.sv =====
// Result channel: fired events, drop flags and stop-audio requests.
`default_nettype none

interface dect_out_if;
  logic             valid;
  logic             ready;
  dect_pkg::field_t fired_id;
  dect_pkg::field_t fired_gain;
  logic             stop_all_audio;
  logic             dropped;
  logic             last;

  modport source (output valid, fired_id, fired_gain, stop_all_audio, dropped, last,
                  input ready);
  modport sink   (input valid, fired_id, fired_gain, stop_all_audio, dropped, last,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dect_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module dect_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/delayed_event_countdown_table.sv =====
// Top level: table of pending delayed sound events, kept in one slot RAM.
//
//   channel   dir  handshake      contents
//   in_ch     in   valid/ready    kind, sound_id, delay, gain, halt_audio
//   out_ch    out  valid/ready    fired_id, fired_gain, stop_all_audio, dropped, last
//
// Request: takes the first free slot; when the table is full it sends a drop result,
// waiting out any result channel stall. One item in flight at a time.
// Tick: walks the slot RAM read/decrement/write-back, and result channel stalls can
// hold the walk; one fired event is held back to mark last.
// Clear: empties the table, plus a stop-audio result when halt_audio is set.
// Valid bits are flops cleared by reset, so no clearing pass is needed.
`default_nettype none

module delayed_event_countdown_table #(
  parameter int SLOTS      = 64,
  parameter int ID_BITS    = 16,
  parameter int DELAY_BITS = 16
) (
  input wire logic   clk,
  input wire logic   rst_n,
  dect_in_if.sink    in_ch,
  dect_out_if.source out_ch
);

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = DELAY_BITS + 1;
  localparam int GAIN_W = dect_pkg::FIELD_W;
  localparam int WORD_W = ID_BITS + GAIN_W + CNT_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_REQ  = 3'd1;
  localparam logic [2:0] S_TICK = 3'd2;
  localparam logic [2:0] S_TEND = 3'd3;
  localparam logic [2:0] S_SEND = 3'd4;

  // control state
  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             rd_done_r, rd_done_nxt;
  logic             s1_v_r, s1_v_nxt;
  logic [IDX_W-1:0] s1_idx_r, s1_idx_nxt;
  logic             hold_v_r, hold_v_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload
  logic [ID_BITS-1:0] req_id_r, req_id_nxt;
  logic [GAIN_W-1:0]  req_gain_r, req_gain_nxt;
  logic [CNT_W-1:0]   req_cnt_r, req_cnt_nxt;
  logic [ID_BITS-1:0] hold_id_r, hold_id_nxt;
  logic [GAIN_W-1:0]  hold_gain_r, hold_gain_nxt;
  logic [ID_BITS-1:0] pend_id_r, pend_id_nxt;
  logic [GAIN_W-1:0]  pend_gain_r, pend_gain_nxt;
  logic               pend_stop_r, pend_stop_nxt;
  logic               pend_drop_r, pend_drop_nxt;
  logic [GAIN_W-1:0]  out_id_r, out_gain_r;
  logic               out_stop_r, out_drop_r, out_last_r;

  // result push into the output register
  logic               push;
  logic [ID_BITS-1:0] push_id;
  logic [GAIN_W-1:0]  push_gain;
  logic               push_stop, push_drop, push_last;
  logic               out_free;

  // RAM ports
  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [WORD_W-1:0]  ram_wdata, ram_rdata;

  logic [ID_BITS-1:0] rd_id;
  logic [GAIN_W-1:0]  rd_gain;
  logic [CNT_W-1:0]   rd_dec;
  logic               s1_live, s1_fire, stall;
  logic               in_acc;

  dect_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign rd_id   = ram_rdata[WORD_W-1 -: ID_BITS];
  assign rd_gain = ram_rdata[CNT_W +: GAIN_W];
  assign rd_dec  = ram_rdata[CNT_W-1:0] - CNT_W'(1);

  assign s1_live = s1_v_r && valid_r[s1_idx_r];
  assign s1_fire = s1_live && (rd_dec == '0);
  // a second firing needs the held one gone before it can take its place
  assign stall   = (state_r == S_TICK) && s1_fire && hold_v_r && !out_free;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    rd_done_nxt   = rd_done_r;
    s1_v_nxt      = s1_v_r;
    s1_idx_nxt    = s1_idx_r;
    hold_v_nxt    = hold_v_r;
    valid_nxt     = valid_r;
    req_id_nxt    = req_id_r;
    req_gain_nxt  = req_gain_r;
    req_cnt_nxt   = req_cnt_r;
    hold_id_nxt   = hold_id_r;
    hold_gain_nxt = hold_gain_r;
    pend_id_nxt   = pend_id_r;
    pend_gain_nxt = pend_gain_r;
    pend_stop_nxt = pend_stop_r;
    pend_drop_nxt = pend_drop_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = {req_id_r, req_gain_r, req_cnt_r};
    ram_re        = 1'b0;
    ram_raddr     = idx_r;
    push          = 1'b0;
    push_id       = '0;
    push_gain     = '0;
    push_stop     = 1'b0;
    push_drop     = 1'b0;
    push_last     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.kind)
            dect_pkg::KIND_REQ: begin
              req_id_nxt   = ID_BITS'(32'(in_ch.sound_id));
              req_gain_nxt = in_ch.gain;
              req_cnt_nxt  = CNT_W'(DELAY_BITS'(32'(in_ch.delay))) + CNT_W'(1);
              idx_nxt      = '0;
              state_nxt    = S_REQ;
            end
            dect_pkg::KIND_TICK: begin
              idx_nxt     = '0;
              rd_done_nxt = 1'b0;
              state_nxt   = S_TICK;
            end
            dect_pkg::KIND_CLEAR: begin
              valid_nxt = '0;
              if (in_ch.halt_audio) begin
                pend_id_nxt   = '0;
                pend_gain_nxt = '0;
                pend_stop_nxt = 1'b1;
                pend_drop_nxt = 1'b0;
                state_nxt     = S_SEND;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_REQ: begin
        if (!valid_r[idx_r]) begin
          ram_we           = 1'b1;
          valid_nxt[idx_r] = 1'b1;
          state_nxt        = S_IDLE;
        end else if (idx_r == IDX_LAST) begin
          pend_id_nxt   = req_id_r;
          pend_gain_nxt = req_gain_r;
          pend_stop_nxt = 1'b0;
          pend_drop_nxt = 1'b1;
          state_nxt     = S_SEND;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_SEND: begin
        if (out_free) begin
          push      = 1'b1;
          push_id   = pend_id_r;
          push_gain = pend_gain_r;
          push_stop = pend_stop_r;
          push_drop = pend_drop_r;
          push_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_TICK: begin
        if (!stall) begin
          if (s1_fire) begin
            valid_nxt[s1_idx_r] = 1'b0;
            if (hold_v_r) begin
              push      = 1'b1;
              push_id   = hold_id_r;
              push_gain = hold_gain_r;
            end
            hold_v_nxt    = 1'b1;
            hold_id_nxt   = rd_id;
            hold_gain_nxt = rd_gain;
          end else if (s1_live) begin
            ram_we    = 1'b1;
            ram_waddr = s1_idx_r;
            ram_wdata = {rd_id, rd_gain, rd_dec};
          end
          s1_v_nxt = 1'b0;
          if (!rd_done_r) begin
            ram_re     = 1'b1;
            s1_v_nxt   = 1'b1;
            s1_idx_nxt = idx_r;
            if (idx_r == IDX_LAST) begin
              rd_done_nxt = 1'b1;
            end else begin
              idx_nxt = idx_r + IDX_W'(1);
            end
          end
          if (s1_v_r && (s1_idx_r == IDX_LAST)) begin
            state_nxt = S_TEND;
          end
        end
      end
      S_TEND: begin
        if (!hold_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          push       = 1'b1;
          push_id    = hold_id_r;
          push_gain  = hold_gain_r;
          push_last  = 1'b1;
          hold_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = push || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      rd_done_r   <= 1'b0;
      s1_v_r      <= 1'b0;
      s1_idx_r    <= '0;
      hold_v_r    <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      rd_done_r   <= rd_done_nxt;
      s1_v_r      <= s1_v_nxt;
      s1_idx_r    <= s1_idx_nxt;
      hold_v_r    <= hold_v_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_id_r    <= req_id_nxt;
    req_gain_r  <= req_gain_nxt;
    req_cnt_r   <= req_cnt_nxt;
    hold_id_r   <= hold_id_nxt;
    hold_gain_r <= hold_gain_nxt;
    pend_id_r   <= pend_id_nxt;
    pend_gain_r <= pend_gain_nxt;
    pend_stop_r <= pend_stop_nxt;
    pend_drop_r <= pend_drop_nxt;
    if (push) begin
      out_id_r   <= GAIN_W'(32'(push_id));
      out_gain_r <= push_gain;
      out_stop_r <= push_stop;
      out_drop_r <= push_drop;
      out_last_r <= push_last;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.fired_id       = out_id_r;
  assign out_ch.fired_gain     = out_gain_r;
  assign out_ch.stop_all_audio = out_stop_r;
  assign out_ch.dropped        = out_drop_r;
  assign out_ch.last           = out_last_r;

  // no held event may survive past the end of a tick
  a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !hold_v_r)
    else $error("held fired event left over in idle");

  // the read pipeline only runs during a tick walk
  a_s1_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> (state_r == S_TICK))
    else $error("slot pipeline active outside tick");

  // a stall keeps the slot in stage one for another try
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> (s1_v_r && (s1_idx_r == $past(s1_idx_r))))
    else $error("stalled slot lost from stage one");

  // a free slot found by a request is taken
  a_req_takes: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_REQ) && !valid_r[idx_r]) |=> valid_r[$past(idx_r)])
    else $error("request did not mark its slot valid");

endmodule

`default_nettype wire

// ===== tb/delayed_event_countdown_table_test.sv =====
// Testbench for the delayed event countdown table: queued stimulus, scoreboard, random stalls.
`timescale 1ns / 1ps

module delayed_event_countdown_table_test;

  typedef dect_pkg::kind_t  kind_t;
  typedef dect_pkg::field_t field_t;

  localparam kind_t KIND_REQ    = dect_pkg::KIND_REQ;
  localparam kind_t KIND_TICK   = dect_pkg::KIND_TICK;
  localparam kind_t KIND_CLEAR  = dect_pkg::KIND_CLEAR;

  localparam int    SLOTS       = 64;
  localparam kind_t KIND_UNUSED = 2'd3;
  localparam int    RAND_ITEMS  = 280;
  localparam int    HOLD_CYCLES = 500;

  typedef struct {
    kind_t  kind;
    field_t sound_id;
    field_t delay;
    field_t gain;
    logic   halt_audio;
  } evt_item_t;

  typedef struct {
    field_t fired_id;
    field_t fired_gain;
    logic   stop_all_audio;
    logic   dropped;
    logic   last;
  } evt_result_t;

  logic clk;
  logic rst_n;

  dect_in_if  in_ch ();
  dect_out_if out_ch ();

  delayed_event_countdown_table uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow copy of the event table
  logic        tbl_valid [SLOTS];
  field_t      tbl_sound [SLOTS];
  field_t      tbl_gain  [SLOTS];
  logic [16:0] tbl_count [SLOTS];

  evt_item_t   stim_q[$];
  evt_result_t due_results[$];
  evt_item_t   cur_item;

  int errors     = 0;
  int n_accepted = 0;
  int n_results  = 0;
  int n_fired    = 0;
  int n_dropped  = 0;
  int n_stops    = 0;
  int n_fills    = 0;
  bit calm       = 1'b0;

  int tx_gap   = 0;
  int tx_quiet = 0;
  int rx_stall = 0;
  int rx_quiet = 0;
  int rx_hold  = 0;
  bit held     = 1'b0;

  task automatic flag_mismatch(string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic evt_item_t mk_item(kind_t k, field_t id, field_t dly, field_t g,
                                        logic stop);
    evt_item_t it;
    it.kind       = k;
    it.sound_id   = id;
    it.delay      = dly;
    it.gain       = g;
    it.halt_audio = stop;
    return it;
  endfunction

  function automatic evt_item_t rand_item(kind_t k);
    field_t dly;
    if ($urandom_range(0, 3) == 0) dly = field_t'($urandom);
    else dly = field_t'($urandom_range(0, 6));
    return mk_item(k, field_t'($urandom), dly, field_t'($urandom), 1'($urandom));
  endfunction

  // Update the shadow table for one accepted transaction, queue what it must produce.
  task automatic table_apply(evt_item_t it);
    evt_result_t r;
    evt_result_t fires[$];
    bit stored;
    stored = 1'b0;
    r = '{fired_id: '0, fired_gain: '0, stop_all_audio: 1'b0, dropped: 1'b0, last: 1'b1};
    case (it.kind)
      KIND_REQ: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!stored && !tbl_valid[i]) begin
            tbl_valid[i] = 1'b1;
            tbl_sound[i] = it.sound_id;
            tbl_gain[i]  = it.gain;
            tbl_count[i] = {1'b0, it.delay} + 17'd1;
            stored = 1'b1;
          end
        end
        if (!stored) begin
          r.fired_id   = it.sound_id;
          r.fired_gain = it.gain;
          r.dropped    = 1'b1;
          due_results.push_back(r);
        end
      end
      KIND_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_valid[i]) begin
            tbl_count[i] = tbl_count[i] - 17'd1;
            if (tbl_count[i] == 17'd0) begin
              r.fired_id   = tbl_sound[i];
              r.fired_gain = tbl_gain[i];
              r.last       = 1'b0;
              fires.push_back(r);
              tbl_valid[i] = 1'b0;
            end
          end
        end
        if (fires.size() > 0) fires[fires.size()-1].last = 1'b1;
        foreach (fires[j]) due_results.push_back(fires[j]);
      end
      KIND_CLEAR: begin
        foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
        if (it.halt_audio) begin
          r.stop_all_audio = 1'b1;
          due_results.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_REQ;
    in_ch.sound_id    = '0;
    in_ch.delay       = '0;
    in_ch.gain        = '0;
    in_ch.halt_audio  = 1'b0;
    out_ch.ready      = 1'b0;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        table_apply(cur_item);
        n_accepted++;
      end
      calm = (stim_q.size() < 40);
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_ch.valid <= 1'b0;
        end else if (stim_q.size() > 0) begin
          cur_item = stim_q.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.kind       <= cur_item.kind;
          in_ch.sound_id   <= cur_item.sound_id;
          in_ch.delay      <= cur_item.delay;
          in_ch.gain       <= cur_item.gain;
          in_ch.halt_audio <= cur_item.halt_audio;
          if (tx_quiet > 0) tx_quiet--;
          else if (!calm && $urandom_range(0, 3) == 0) tx_gap = $urandom_range(1, 10);
          else if ($urandom_range(0, 19) == 0) tx_quiet = $urandom_range(10, 30);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result sink: short random stalls plus one long hold-off that backs up the input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_ch.ready <= 1'b0;
    end else if (!held && n_results >= 20 && !calm) begin
      held    = 1'b1;
      rx_hold = HOLD_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_stall == 0) begin
        if (rx_quiet > 0) rx_quiet--;
        else if (!calm && $urandom_range(0, 7) == 0) rx_stall = $urandom_range(1, 10);
        else if ($urandom_range(0, 29) == 0) rx_quiet = $urandom_range(20, 60);
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    evt_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (out_ch.dropped) n_dropped++;
      else if (out_ch.stop_all_audio) n_stops++;
      else n_fired++;
      if (due_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result id=%h gain=%h stop=%b drop=%b last=%b",
                                out_ch.fired_id, out_ch.fired_gain, out_ch.stop_all_audio,
                                out_ch.dropped, out_ch.last));
      end else begin
        want = due_results.pop_front();
        if (out_ch.fired_id !== want.fired_id)
          flag_mismatch($sformatf("fired_id %h, want %h", out_ch.fired_id, want.fired_id));
        if (out_ch.fired_gain !== want.fired_gain)
          flag_mismatch($sformatf("fired_gain %h, want %h", out_ch.fired_gain,
                                  want.fired_gain));
        if (out_ch.stop_all_audio !== want.stop_all_audio)
          flag_mismatch($sformatf("stop_all_audio %b, want %b", out_ch.stop_all_audio,
                                  want.stop_all_audio));
        if (out_ch.dropped !== want.dropped)
          flag_mismatch($sformatf("dropped %b, want %b", out_ch.dropped, want.dropped));
        if (out_ch.last !== want.last)
          flag_mismatch($sformatf("last %b, want %b", out_ch.last, want.last));
      end
    end
  end

  initial begin
    int n_rand;
    int seg;
    int pick;

    // directed: field extremes, zero and max delay, same-tick multi-fire, clears, unused kind
    stim_q.push_back(mk_item(KIND_REQ, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    stim_q.push_back(mk_item(KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    stim_q.push_back(mk_item(KIND_REQ, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1));
    stim_q.push_back(mk_item(KIND_REQ, 16'h1234, 16'h0001, 16'h4000, 1'b0));
    stim_q.push_back(mk_item(KIND_REQ, 16'h5555, 16'h0000, 16'hAAAA, 1'b0));
    stim_q.push_back(mk_item(KIND_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    stim_q.push_back(mk_item(KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    stim_q.push_back(mk_item(KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    stim_q.push_back(mk_item(KIND_REQ, 16'hAAAA, 16'hFFFF, 16'h5555, 1'b0));
    stim_q.push_back(mk_item(KIND_REQ, 16'h00FF, 16'h8000, 16'hFF00, 1'b0));
    stim_q.push_back(mk_item(KIND_CLEAR, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    stim_q.push_back(mk_item(KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    stim_q.push_back(mk_item(KIND_CLEAR, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    stim_q.push_back(mk_item(KIND_UNUSED, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1));
    stim_q.push_back(mk_item(KIND_REQ, 16'h0F0F, 16'h0002, 16'h7FFF, 1'b1));
    stim_q.push_back(mk_item(KIND_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    stim_q.push_back(mk_item(KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    stim_q.push_back(mk_item(KIND_REQ, 16'hC3C3, 16'h0000, 16'h8000, 1'b0));
    stim_q.push_back(mk_item(KIND_UNUSED, 16'h0000, 16'hFFFF, 16'h0000, 1'b0));
    stim_q.push_back(mk_item(KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0));

    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      seg = $urandom_range(0, 9);
      if ((seg == 0 && n_fills < 2) || (n_fills == 0 && n_rand > 120)) begin
        // overfill the table so requests get dropped, then drain a little and clear
        n_fills++;
        repeat (SLOTS + $urandom_range(3, 8)) begin
          stim_q.push_back(rand_item(KIND_REQ));
          n_rand++;
        end
        repeat ($urandom_range(2, 5)) begin
          stim_q.push_back(rand_item(KIND_TICK));
          n_rand++;
        end
        stim_q.push_back(rand_item(KIND_CLEAR));
        n_rand++;
      end else begin
        repeat (10) begin
          pick = $urandom_range(0, 99);
          if (pick < 45) begin
            stim_q.push_back(rand_item(KIND_REQ));
            n_rand++;
          end else if (pick < 85) begin
            stim_q.push_back(rand_item(KIND_TICK));
            n_rand++;
          end else if (pick < 92) begin
            stim_q.push_back(rand_item(KIND_CLEAR));
            n_rand++;
          end else begin
            stim_q.push_back(rand_item(KIND_UNUSED));
          end
        end
      end
    end
    // flush whatever is still pending so the tail produces results too
    repeat (8) stim_q.push_back(rand_item(KIND_TICK));

    while (!rst_n) @(posedge clk);
    while (stim_q.size() > 0 || in_ch.valid) @(posedge clk);
    while (due_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Ran %0d transactions through the table (%0d full-table bursts,",
             n_accepted, n_fills);
    $display("one long sink hold-off); checked %0d results: %0d fired, %0d dropped,",
             n_results, n_fired, n_dropped);
    $display("%0d stop-audio; %0d mismatches.", n_stops, errors);
    if (errors == 0 && due_results.size() == 0) begin
      $display("delayed_event_countdown_table verification clean");
    end else begin
      $display("delayed_event_countdown_table verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d results still outstanding.", due_results.size());
    $display("delayed_event_countdown_table verification failed");
    $finish;
  end

endmodule
